@@ rtl/gap_pkg.sv @@
package gap_pkg;

	// Accumulator and quotient width, fixed by the arithmetic of the block.
	localparam int ACC_W  = 32;
	// Bits needed to count the serial division steps, one per quotient bit.
	localparam int STEP_W = $clog2(ACC_W);

	typedef logic signed [ACC_W-1:0] acc_t;

	// Top-level sequencer states.
	typedef enum logic [1:0] {
		ST_ACCUM,
		ST_DIVIDE,
		ST_OUTPUT
	} gap_state_t;

	// Divider sequencer states.
	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_SIGN
	} div_state_t;

endpackage

@@ rtl/gap_div.sv @@
module gap_div #(
	parameter int DIV_W = 17
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  gap_pkg::acc_t       dividend,
	input  logic [DIV_W-1:0]    divisor,
	output logic                done,
	output gap_pkg::acc_t       quotient
);

	gap_pkg::div_state_t             state_q;
	gap_pkg::div_state_t             state_d;
	logic [gap_pkg::STEP_W-1:0]      step_q;
	logic                            done_q;
	logic [DIV_W-1:0]                rem_q;
	logic [gap_pkg::ACC_W-1:0]       quo_q;
	logic [DIV_W-1:0]                dvs_q;
	logic                            neg_q;
	logic [DIV_W:0]                  trial;
	logic [DIV_W:0]                  diff;
	logic                            fits;
	logic                            last_step;
	logic [gap_pkg::ACC_W-1:0]       magnitude;

	// Divide the magnitude and fix the sign at the end, so the quotient truncates toward zero.
	assign magnitude = dividend[gap_pkg::ACC_W-1] ? -dividend : dividend;

	// Shared restoring step: shift in the next dividend bit and try a subtract.
	assign trial     = {rem_q, quo_q[gap_pkg::ACC_W-1]};
	assign diff      = trial - {1'b0, dvs_q};
	assign fits      = ~diff[DIV_W];
	assign last_step = (step_q == gap_pkg::STEP_W'(gap_pkg::ACC_W - 1));

	// Next-state logic for the step sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			gap_pkg::DIV_IDLE: begin
				if (start) begin
					state_d = gap_pkg::DIV_RUN;
				end
			end
			gap_pkg::DIV_RUN: begin
				if (last_step) begin
					state_d = gap_pkg::DIV_SIGN;
				end
			end
			gap_pkg::DIV_SIGN: begin
				state_d = gap_pkg::DIV_IDLE;
			end
			default: begin
				state_d = gap_pkg::DIV_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gap_pkg::DIV_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == gap_pkg::DIV_SIGN);
			if (state_q == gap_pkg::DIV_RUN) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

	// Datapath registers: load, one quotient bit per cycle, then apply the sign.
	always_ff @(posedge clk) begin
		case (state_q)
			gap_pkg::DIV_IDLE: begin
				if (start) begin
					rem_q <= '0;
					quo_q <= magnitude;
					dvs_q <= divisor;
					neg_q <= dividend[gap_pkg::ACC_W-1];
				end
			end
			gap_pkg::DIV_RUN: begin
				if (fits) begin
					rem_q <= diff[DIV_W-1:0];
				end else begin
					rem_q <= trial[DIV_W-1:0];
				end
				quo_q <= {quo_q[gap_pkg::ACC_W-2:0], fits};
			end
			gap_pkg::DIV_SIGN: begin
				if (neg_q) begin
					quo_q <= -quo_q;
				end
			end
			default: begin
				quo_q <= quo_q;
			end
		endcase
	end

	assign done     = done_q;
	assign quotient = gap_pkg::acc_t'(quo_q);

endmodule

@@ rtl/global_average_pool.sv @@
// Plane samples that do not close a plane are taken one per cycle.
// The sample that closes a plane starts a 32-step serial divider (one quotient bit a cycle);
// s_axis_tready stays low while the divider runs and until the average is loaded into the output register,
// which waits while an earlier average is still held there unaccepted; the average then appears on m_axis.
// Reset (arst_n low, asynchronous) clears the sum, the sample count and the output valid,
// and sets the plane size to one.
module global_average_pool #(
	parameter int MAX_PLANE_LOG2 = 16,
	parameter int SAMPLE_WIDTH   = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// Fields from bit 0: sample.
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// Fields from bit 0: average.
	output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
	input  logic                                 plane_size_we,
	input  logic [MAX_PLANE_LOG2:0]              plane_size
);

	localparam int SIZE_W  = MAX_PLANE_LOG2 + 1;
	localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
	localparam logic [SIZE_W-1:0] PLANE_MAX = {1'b1, {MAX_PLANE_LOG2{1'b0}}};

	gap_pkg::gap_state_t            state_q;
	gap_pkg::gap_state_t            state_d;
	logic [SIZE_W-1:0]              eff_size_q;
	logic [SIZE_W-1:0]              count_q;
	logic [SIZE_W-1:0]              count_next;
	gap_pkg::acc_t                  sum_q;
	gap_pkg::acc_t                  sum_next;
	logic signed [SAMPLE_WIDTH-1:0] sample_s;
	logic                           accept;
	logic                           plane_end;
	logic                           out_load;
	logic                           out_valid_q;
	logic [SAMPLE_WIDTH-1:0]        average_q;
	logic                           div_done;
	gap_pkg::acc_t                  div_quotient;

	assign sample_s   = s_axis_tdata[SAMPLE_WIDTH-1:0];
	assign accept     = s_axis_tvalid && s_axis_tready;
	assign sum_next   = sum_q + gap_pkg::ACC_W'(sample_s);
	assign count_next = count_q + 1'b1;
	assign plane_end  = (count_next >= eff_size_q);

	// Plane size register: zero counts as one, and sizes past the maximum are clamped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_size_q <= SIZE_W'(1);
		end else if (plane_size_we) begin
			if (plane_size == '0) begin
				eff_size_q <= SIZE_W'(1);
			end else if (plane_size > PLANE_MAX) begin
				eff_size_q <= PLANE_MAX;
			end else begin
				eff_size_q <= plane_size;
			end
		end
	end

	// Sequencer: accumulate, wait for the divider, then hand the average to the output register.
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			gap_pkg::ST_ACCUM: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid && plane_end) begin
					state_d = gap_pkg::ST_DIVIDE;
				end
			end
			gap_pkg::ST_DIVIDE: begin
				if (div_done) begin
					state_d = gap_pkg::ST_OUTPUT;
				end
			end
			gap_pkg::ST_OUTPUT: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = gap_pkg::ST_ACCUM;
				end
			end
			default: begin
				state_d = gap_pkg::ST_ACCUM;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gap_pkg::ST_ACCUM;
		end else begin
			state_q <= state_d;
		end
	end

	// Running sum and sample count of the current plane.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (plane_end) begin
				sum_q   <= '0;
				count_q <= '0;
			end else begin
				sum_q   <= sum_next;
				count_q <= count_next;
			end
		end
	end

	// Serial divider shared by every plane.
	gap_div #(
		.DIV_W (SIZE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && plane_end),
		.dividend (sum_next),
		.divisor  (eff_size_q),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// Output register holds one result until the downstream side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			average_q <= div_quotient[SAMPLE_WIDTH-1:0];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = TDATA_W'(average_q);

`ifndef SYNTHESIS
	// The divider reports completion only while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == gap_pkg::ST_DIVIDE))
		else $error("divider done outside the divide state");

	// Closing a plane clears the sum and count and starts the division.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && plane_end) |=>
			(state_q == gap_pkg::ST_DIVIDE) && (count_q == '0) && (sum_q == '0))
		else $error("plane end did not clear the accumulator");

	// A sample inside a plane advances the count by exactly one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !plane_end) |=> (count_q == $past(count_q) + 1'b1))
		else $error("sample count did not advance");

	// A pending result is never overwritten while the output side stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == gap_pkg::ST_OUTPUT) && out_valid_q && !m_axis_tready) |=>
			(state_q == gap_pkg::ST_OUTPUT) && $stable(average_q))
		else $error("stalled result was overwritten");
`endif

endmodule

@@ tb/testbench.sv @@
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DATA_W = 16;
	localparam int SIZE_W = 17;
	// The divider keeps the input stalled after a plane closes.
	localparam int SETTLE_CYCLES = 45;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int HOLD_CYCLES = 300;
	localparam int ROW_COUNT = 24;

	// One line of the directed stimulus table: an optional plane size write,
	// then one sample sent reps times, with an optional fixed expected average.
	typedef struct {
		bit                       cfg_en;
		logic [SIZE_W-1:0]        cfg_val;
		logic signed [DATA_W-1:0] sample;
		int                       reps;
		bit                       exp_en;
		logic signed [DATA_W-1:0] exp_val;
	} pool_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	// Fields from bit 0: sample.
	logic [DATA_W-1:0]   s_axis_tdata = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	// Fields from bit 0: average.
	logic [DATA_W-1:0]   m_axis_tdata;
	logic                plane_size_we = 1'b0;
	logic [SIZE_W-1:0]   plane_size = '0;

	// Model of the block: running sum, samples taken, programmed plane size.
	logic signed [31:0]  plane_total = '0;
	logic [SIZE_W-1:0]   plane_taken = '0;
	logic [SIZE_W-1:0]   plane_len = 1;

	logic signed [DATA_W-1:0] averages_due [$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int errors = 0;
	int samples_sent = 0;
	int averages_seen = 0;
	int size_writes = 0;

	pool_row_t directed_rows [ROW_COUNT] = '{
		// Default plane size of one after reset: each sample is its own average.
		'{1'b0, 0, 0, 1, 1'b1, 0},
		'{1'b0, 0, 32767, 1, 1'b1, 32767},
		'{1'b0, 0, -32768, 1, 1'b1, -32768},
		'{1'b0, 0, 1, 1, 1'b1, 1},
		'{1'b0, 0, -1, 1, 1'b1, -1},
		// A plane size of zero behaves as one.
		'{1'b1, 0, 16'sh1234, 1, 1'b1, 16'sh1234},
		'{1'b0, 0, -300, 1, 1'b1, -300},
		// Two-sample planes, with odd sums truncated toward zero.
		'{1'b1, 2, 3, 2, 1'b1, 3},
		'{1'b0, 0, 3, 1, 1'b0, 0},
		'{1'b0, 0, 0, 1, 1'b0, 0},
		'{1'b0, 0, -3, 1, 1'b0, 0},
		'{1'b0, 0, 0, 1, 1'b0, 0},
		// Size shrinks in the middle of a plane.
		'{1'b1, 4, 100, 2, 1'b0, 0},
		'{1'b1, 2, 50, 1, 1'b0, 0},
		// Size grows in the middle of a plane.
		'{1'b0, 0, 7, 1, 1'b0, 0},
		'{1'b1, 5, 7, 4, 1'b0, 0},
		// Size drops to one in the middle of a plane.
		'{1'b1, 3, 10, 1, 1'b0, 0},
		'{1'b1, 1, 10, 1, 1'b0, 0},
		'{1'b1, 3, 32767, 2, 1'b0, 0},
		'{1'b0, 0, -32768, 1, 1'b0, 0},
		// Full-scale planes at both sample extremes; sizes above the limit clamp.
		'{1'b1, 64, -32768, 64, 1'b1, -32768},
		'{1'b1, 64, 32767, 64, 1'b1, 32767},
		'{1'b1, 65537, -5, 3, 1'b0, 0},
		'{1'b1, 1, -7, 1, 1'b0, 0}
	};

	global_average_pool dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.plane_size_we (plane_size_we),
		.plane_size    (plane_size)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Accumulate one sample; returns 1 with the average when the plane closes.
	function automatic bit pool_sample(input logic signed [DATA_W-1:0] value,
			output logic signed [DATA_W-1:0] average);
		logic [SIZE_W-1:0] eff_len;
		longint            quotient;
		eff_len = plane_len;
		if (eff_len == 0) begin
			eff_len = 1;
		end else if (eff_len > 65536) begin
			eff_len = 65536;
		end
		plane_total = plane_total + 32'(value);
		plane_taken = plane_taken + 1'b1;
		average = '0;
		if (plane_taken < eff_len) begin
			return 1'b0;
		end
		quotient = longint'(plane_total) / longint'(eff_len);
		average = quotient[DATA_W-1:0];
		plane_total = '0;
		plane_taken = '0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH at %0t ns: %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	// Offer one sample, with random idle cycles before it, until it is taken.
	task automatic send_sample(input logic signed [DATA_W-1:0] value);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		do @(posedge clk); while (!s_axis_tready);
		samples_sent++;
	endtask

	task automatic feed(input logic signed [DATA_W-1:0] value, input bit fixed_en,
			input logic signed [DATA_W-1:0] fixed_val);
		logic signed [DATA_W-1:0] average;
		send_sample(value);
		if (pool_sample(value, average)) begin
			averages_due.push_back(fixed_en ? fixed_val : average);
		end
	endtask

	// Wait until every pending average is out and the divider has gone quiet.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (averages_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_plane_size(input logic [SIZE_W-1:0] value);
		settle();
		plane_size_we <= 1'b1;
		plane_size <= value;
		@(posedge clk);
		plane_size_we <= 1'b0;
		plane_len = value;
		size_writes++;
	endtask

	function automatic logic [SIZE_W-1:0] pick_plane_len();
		case ($urandom_range(9))
			0: begin
				return 0;
			end
			1, 2: begin
				return SIZE_W'($urandom_range(7, 24));
			end
			default: begin
				return SIZE_W'($urandom_range(1, 6));
			end
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_sample();
		logic [31:0] raw;
		raw = $urandom();
		case ($urandom_range(7))
			0: begin
				return -32768;
			end
			1: begin
				return 32767;
			end
			default: begin
				return raw[DATA_W-1:0];
			end
		endcase
	endfunction

	// Output side: check each average taken and decide the ready for the next cycle.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			averages_seen++;
			if (averages_due.size() == 0) begin
				report_mismatch("average with nothing pending",
					$signed(m_axis_tdata), 0);
			end else begin
				if (m_axis_tdata !== averages_due[0]) begin
					report_mismatch("average", $signed(m_axis_tdata), averages_due[0]);
				end
				void'(averages_due.pop_front());
			end
		end
		if (hold_req && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		#10ms;
		$display("Timeout at %0t ns with %0d averages pending", $realtime,
			averages_due.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int left;
		int chunk;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed table, no idling on either side.
		foreach (directed_rows[i]) begin
			if (directed_rows[i].cfg_en) begin
				write_plane_size(directed_rows[i].cfg_val);
			end
			repeat (directed_rows[i].reps) begin
				feed(directed_rows[i].sample, directed_rows[i].exp_en,
					directed_rows[i].exp_val);
			end
		end

		// Random phases with different idle and stall mixes.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 45;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 45;
				end
				default: begin
					send_idle_pct = 23;
					stall_pct = 23;
				end
			endcase
			left = ITEMS_PER_PHASE;
			if (phase == 0) begin
				// Hold the output off while single-sample planes keep coming.
				write_plane_size(1);
				hold_req = 1'b1;
				repeat (24) feed(pick_sample(), 1'b0, 0);
				left -= 24;
			end
			while (left > 0) begin
				write_plane_size(pick_plane_len());
				chunk = $urandom_range(8, 40);
				if (chunk > left) begin
					chunk = left;
				end
				repeat (chunk) feed(pick_sample(), 1'b0, 0);
				left -= chunk;
			end
		end

		s_axis_tvalid <= 1'b0;
		while (averages_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d samples and checked %0d plane averages across %0d plane size writes,",
			samples_sent, averages_seen, size_writes);
		$display("including clamped and zero sizes, mid-plane size changes and output back-pressure.");
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
rtl/gap_pkg.sv
rtl/gap_div.sv
rtl/global_average_pool.sv
tb/testbench.sv
